// ===== src/mvt_pkg.sv =====
// Shared types and constants for the mobility visitor table.
package mvt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [15:0] REG_PORT  = 16'd434;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [7:0]  MT_REQ    = 8'd1;
    localparam logic [7:0]  CODE_OK   = 8'd1;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_REQ   = 2'd1,
        CMD_REPLY = 2'd2,
        CMD_DETUN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_PASS    = 2'd0,
        ACT_REWRITE = 2'd1,
        ACT_FWD     = 2'd2,
        ACT_DROP    = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_MATCH,
        ST_SEL,
        ST_DECIDE,
        ST_RENUM,
        ST_APPEND,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic match;
        logic select;
        logic tick_upd;
        logic remove_sel;
        logic activate;
        logic renum;
        logic append;
        logic res_pass;
        logic res_drop;
        logic res_fwd;
        logic res_reply;
        logic emit;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic is_reg;
        logic mtype_req;
        logic code_ok;
        logic found;
        logic sel_active;
        logic out_free;
    } t_sts;

endpackage

// ===== src/mvt_ctrl.sv =====
// Sequencer for the visitor table: steps each beat through lookup and update.
module mvt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mvt_pkg::t_sts i_sts,
    output mvt_pkg::t_ctl o_ctl
);
    import mvt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_sts.cmd == CMD_TICK) ? ST_TICK : ST_MATCH;
                end
            end
            ST_TICK:   n_state = ST_RENUM;
            ST_MATCH:  n_state = ST_SEL;
            ST_SEL:    n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_sts.cmd == CMD_REQ && i_sts.is_reg && i_sts.mtype_req) begin
                    n_state = ST_RENUM;
                end else if (i_sts.cmd == CMD_REPLY && i_sts.is_reg && i_sts.found &&
                             !i_sts.code_ok) begin
                    n_state = ST_RENUM;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_RENUM: begin
                if (i_sts.cmd == CMD_TICK) begin
                    n_state = ST_IDLE;
                end else if (i_sts.cmd == CMD_REQ) begin
                    n_state = ST_APPEND;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_APPEND: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctl.load_in = i_in_valid;
            end
            ST_TICK:  o_ctl.tick_upd = 1'b1;
            ST_MATCH: o_ctl.match = 1'b1;
            ST_SEL:   o_ctl.select = 1'b1;
            ST_DECIDE: begin
                unique case (i_sts.cmd)
                    CMD_DETUN: begin
                        if (i_sts.found && i_sts.sel_active) begin
                            o_ctl.res_fwd = 1'b1;
                        end else begin
                            o_ctl.res_drop = 1'b1;
                        end
                    end
                    CMD_REQ: begin
                        if (!i_sts.is_reg) begin
                            o_ctl.res_pass = 1'b1;
                        end else if (!i_sts.mtype_req) begin
                            o_ctl.res_drop = 1'b1;
                        end else begin
                            o_ctl.res_pass   = 1'b1;
                            o_ctl.remove_sel = i_sts.found;
                        end
                    end
                    CMD_REPLY: begin
                        if (!i_sts.is_reg) begin
                            o_ctl.res_pass = 1'b1;
                        end else if (!i_sts.found) begin
                            o_ctl.res_drop = 1'b1;
                        end else begin
                            o_ctl.res_reply  = 1'b1;
                            o_ctl.activate   = i_sts.code_ok;
                            o_ctl.remove_sel = !i_sts.code_ok;
                        end
                    end
                    default: o_ctl.res_drop = 1'b1;
                endcase
            end
            ST_RENUM:  o_ctl.renum = 1'b1;
            ST_APPEND: o_ctl.append = 1'b1;
            ST_EMIT:   o_ctl.emit = i_sts.out_free;
            default:   o_ctl = '0;
        endcase
    end

endmodule

// ===== src/mvt_dp.sv =====
// Visitor table storage, parallel lookup, aging and the result register.
module mvt_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic [1:0]    i_cmd,
    input  logic [215:0]  i_data,
    input  mvt_pkg::t_ctl i_ctl,
    output mvt_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [2:0]    o_out_user,
    output logic [143:0]  o_out_data
);
    import mvt_pkg::*;

    logic [31:0] r_own_ip;

    t_cmd        r_cmd;
    logic [47:0] r_mac;
    logic [31:0] r_isrc, r_idst, r_idl;
    logic [7:0]  r_proto, r_mtype, r_code;
    logic [15:0] r_sport, r_dport, r_life;

    logic [TABLE_ENTRIES-1:0] r_valid, r_active, r_match, r_sel;
    logic [47:0]      r_e_mac   [TABLE_ENTRIES];
    logic [31:0]      r_e_sip   [TABLE_ENTRIES];
    logic [31:0]      r_e_dip   [TABLE_ENTRIES];
    logic [15:0]      r_e_sport [TABLE_ENTRIES];
    logic [31:0]      r_e_id    [TABLE_ENTRIES];
    logic [15:0]      r_e_rem   [TABLE_ENTRIES];
    logic [IDX_W-1:0] r_e_rank  [TABLE_ENTRIES];

    logic             r_is_reg, r_found;
    logic [IDX_W-1:0] r_k;

    t_act        r_res_act;
    logic [47:0] r_res_mac;
    logic [31:0] r_res_src, r_res_dst;
    logic [15:0] r_res_sport, r_res_dport;
    logic        r_res_full;

    logic         r_ovalid;
    logic [2:0]   r_ouser;
    logic [143:0] r_odata;

    logic [TABLE_ENTRIES-1:0] n_match, n_sel;
    logic [IDX_W-1:0]         n_k, n_free;
    logic                     n_has_free;
    logic [CNT_W-1:0]         n_cnt;
    logic [CNT_W-1:0]         n_rank [TABLE_ENTRIES];
    logic                     n_is_reg;

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            unique case (r_cmd)
                CMD_REPLY: n_match[i] = r_valid[i] && (r_e_id[i] == r_idl);
                CMD_DETUN: n_match[i] = r_valid[i] && (r_e_sip[i] == r_idst);
                default:   n_match[i] = r_valid[i] && (r_e_sip[i] == r_isrc);
            endcase
        end
        n_is_reg = ((r_idst == r_own_ip) || (r_isrc == r_own_ip)) && (r_proto == PROTO_UDP) &&
                   ((r_dport == REG_PORT) || (r_sport == REG_PORT));
    end

    always_comb begin
        n_k = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_sel[i] = r_match[i];
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                if (r_match[j] && (r_e_rank[j] < r_e_rank[i])) begin
                    n_sel[i] = 1'b0;
                end
            end
            if (n_sel[i]) begin
                n_k = n_k | IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_free     = '0;
        n_has_free = 1'b0;
        n_cnt      = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                n_free     = IDX_W'(i);
                n_has_free = 1'b1;
            end
            n_cnt = n_cnt + CNT_W'(r_valid[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_rank[i] = '0;
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                n_rank[i] = n_rank[i] +
                            CNT_W'(r_valid[j] && (r_e_rank[j] < r_e_rank[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_we) begin
            r_own_ip <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_mac   <= i_data[47:0];
            r_isrc  <= i_data[79:48];
            r_idst  <= i_data[111:80];
            r_proto <= i_data[119:112];
            r_sport <= i_data[135:120];
            r_dport <= i_data[151:136];
            r_mtype <= i_data[159:152];
            r_idl   <= i_data[191:160];
            r_life  <= i_data[207:192];
            r_code  <= i_data[215:208];
        end
        if (i_ctl.match) begin
            r_match  <= n_match;
            r_is_reg <= n_is_reg;
        end
        if (i_ctl.select) begin
            r_sel   <= n_sel;
            r_k     <= n_k;
            r_found <= |r_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= '0;
        end else begin
            if (i_ctl.tick_upd) begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (r_valid[i] && (r_e_rem[i] <= 16'd1)) begin
                        r_valid[i]  <= 1'b0;
                        r_active[i] <= 1'b0;
                    end
                end
            end
            if (i_ctl.activate) begin
                r_active[r_k] <= 1'b1;
            end
            if (i_ctl.remove_sel) begin
                r_valid[r_k]  <= 1'b0;
                r_active[r_k] <= 1'b0;
            end
            if (i_ctl.append && n_has_free) begin
                r_valid[n_free]  <= 1'b1;
                r_active[n_free] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tick_upd) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (r_valid[i] && (r_e_rem[i] > 16'd1)) begin
                    r_e_rem[i] <= r_e_rem[i] - 16'd1;
                end
            end
        end
        if (i_ctl.renum) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (r_valid[i]) begin
                    r_e_rank[i] <= n_rank[i][IDX_W-1:0];
                end
            end
        end
        if (i_ctl.append && n_has_free) begin
            r_e_mac[n_free]   <= r_mac;
            r_e_sip[n_free]   <= r_isrc;
            r_e_dip[n_free]   <= r_idst;
            r_e_sport[n_free] <= r_sport;
            r_e_id[n_free]    <= r_idl;
            r_e_rem[n_free]   <= r_life;
            r_e_rank[n_free]  <= n_cnt[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_pass) begin
            r_res_act   <= ACT_PASS;
            r_res_mac   <= '0;
            r_res_src   <= r_isrc;
            r_res_dst   <= r_idst;
            r_res_sport <= r_sport;
            r_res_dport <= r_dport;
            r_res_full  <= 1'b0;
        end
        if (i_ctl.res_drop) begin
            r_res_act   <= ACT_DROP;
            r_res_mac   <= '0;
            r_res_src   <= '0;
            r_res_dst   <= '0;
            r_res_sport <= '0;
            r_res_dport <= '0;
            r_res_full  <= 1'b0;
        end
        if (i_ctl.res_fwd) begin
            r_res_act   <= ACT_FWD;
            r_res_mac   <= r_e_mac[r_k];
            r_res_src   <= r_isrc;
            r_res_dst   <= r_idst;
            r_res_sport <= r_sport;
            r_res_dport <= r_dport;
            r_res_full  <= 1'b0;
        end
        if (i_ctl.res_reply) begin
            r_res_act   <= ACT_REWRITE;
            r_res_mac   <= r_e_mac[r_k];
            r_res_src   <= r_e_dip[r_k];
            r_res_dst   <= r_e_sip[r_k];
            r_res_sport <= REG_PORT;
            r_res_dport <= r_e_sport[r_k];
            r_res_full  <= 1'b0;
        end
        if (i_ctl.append) begin
            r_res_full <= !n_has_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_ouser <= {r_res_full, r_res_act};
            r_odata <= {r_res_dport, r_res_sport, r_res_dst, r_res_src, r_res_mac};
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.is_reg     = r_is_reg;
        o_sts.mtype_req  = (r_mtype == MT_REQ);
        o_sts.code_ok    = (r_code == CODE_OK);
        o_sts.found      = r_found;
        o_sts.sel_active = |(r_sel & r_active);
        o_sts.out_free   = !r_ovalid || i_out_ready;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_user  = r_ouser;
    assign o_out_data  = r_odata;

endmodule

// ===== src/mobility_visitor_table.sv =====
// Top level of the mobile IP foreign-agent visitor table.
// Each beat takes a packet summary or a one-second tick (s_axis_tuser = 0) and the
// table answers with one result beat per packet, none per tick. From acceptance until
// its result is loaded into the output register, a packet steps through accept, match,
// oldest-entry select, decide and emit; a denied reply adds renumber and a registration
// request adds renumber and append; a tick steps through accept, age and renumber.
// The controller handles one beat at a time; a finished result waits in the output
// register while the next beat is accepted and processed; emit stalls while it is full.
module mobility_visitor_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // src_mac, ip_src, ip_dst, ip_proto, udp_sport, udp_dport, msg_type, id_low,
    // lifetime, reply_code
    input  logic [215:0] s_axis_tdata,
    // cmd
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dst_mac, new_ip_src, new_ip_dst, new_sport, new_dport
    output logic [143:0] m_axis_tdata,
    // action, table_full
    output logic [2:0]   m_axis_tuser
);
    import mvt_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts, w_sts_c;

    always_comb begin
        w_sts_c = w_sts;
        if (s_axis_tready) begin
            w_sts_c.cmd = t_cmd'(s_axis_tuser);
        end
    end

    mvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts_c),
        .o_ctl      (w_ctl)
    );

    mvt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_user  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule
